// ----- sv/euler_angles_to_rotation_defines.svh -----
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_defines
// Assertion macros for the rotation block.
// ----------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_ROTATION_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_DEFINES_SVH

// Implication checked on every edge outside reset
`define EAR_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked outside reset
`define EAR_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- sv/ear_pkg.sv -----
// ----------------------------------------------------------------------------
// ear_pkg
// Constants and types shared by the Euler-angle rotation block.
// ----------------------------------------------------------------------------
package ear_pkg;

    localparam int ATAB_LEN = 24;
    localparam int QW       = 34;   // Q.30 working width with headroom

    typedef logic signed [QW-1:0] t_q30;

    localparam logic signed [QW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [QW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [QW-1:0] Q30_GAIN    = 34'sd652032874;

    // Truncated Q.30 arctangent of 2^-i
    function automatic t_q30 atan_q30(input int idx);
        t_q30 v;
        begin
            case (idx)
                0: v = 34'sd843314856;   1: v = 34'sd497837829;
                2: v = 34'sd263043836;   3: v = 34'sd133525158;
                4: v = 34'sd67021686;    5: v = 34'sd33543515;
                6: v = 34'sd16775850;    7: v = 34'sd8388437;
                8: v = 34'sd4194282;     9: v = 34'sd2097149;
                10: v = 34'sd1048575;    11: v = 34'sd524287;
                12: v = 34'sd262143;     13: v = 34'sd131071;
                14: v = 34'sd65535;      15: v = 34'sd32767;
                16: v = 34'sd16383;      17: v = 34'sd8191;
                18: v = 34'sd4095;       19: v = 34'sd2047;
                20: v = 34'sd1023;       21: v = 34'sd511;
                22: v = 34'sd255;        23: v = 34'sd127;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Rounded Q.30 product, half up
    function automatic t_q30 qmul(input t_q30 a, input t_q30 b);
        logic signed [2*QW-1:0] p;
        begin
            p = 68'(a) * 68'(b) + 68'sd536870912;
            return QW'(p >>> 30);
        end
    endfunction

endpackage

// ----- sv/ear_cordic.sv -----
// ----------------------------------------------------------------------------
// ear_cordic
// Pipelined CORDIC: one stage per register, sine and cosine of one angle.
// ----------------------------------------------------------------------------
module ear_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic [15:0]        i_angle,
    output ear_pkg::t_q30      o_sin,
    output ear_pkg::t_q30      o_cos
);
    localparam int NS = (CORDIC_STAGES < ear_pkg::ATAB_LEN) ? CORDIC_STAGES
                                                            : ear_pkg::ATAB_LEN;

    ear_pkg::t_q30 r_x [NS+1];
    ear_pkg::t_q30 r_y [NS+1];
    ear_pkg::t_q30 r_z [NS+1];
    logic          r_flip [NS+1];

    // Reduce the angle into the convergence range
    ear_pkg::t_q30 n_z0;
    logic          n_flip0;
    always_comb begin
        n_z0 = ear_pkg::t_q30'($signed(i_angle)) <<< 17;
        n_flip0 = 1'b0;
        if (n_z0 > ear_pkg::Q30_HALF_PI) begin
            n_z0 = n_z0 - ear_pkg::Q30_PI;
            n_flip0 = 1'b1;
        end else if (n_z0 < -ear_pkg::Q30_HALF_PI) begin
            n_z0 = n_z0 + ear_pkg::Q30_PI;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= ear_pkg::Q30_GAIN;
        r_y[0] <= '0;
        r_z[0] <= n_z0;
        r_flip[0] <= n_flip0;
    end

    // Rotate by one micro-angle per stage
    for (genvar g = 0; g < NS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!r_z[g][ear_pkg::QW-1]) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - ear_pkg::atan_q30(g);
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + ear_pkg::atan_q30(g);
            end
            r_flip[g+1] <= r_flip[g];
        end
    end

    assign o_sin = r_flip[NS] ? -r_y[NS] : r_y[NS];
    assign o_cos = r_flip[NS] ? -r_x[NS] : r_x[NS];

endmodule

// ----- sv/euler_angles_to_rotation.sv -----
// ----------------------------------------------------------------------------
// euler_angles_to_rotation
// Three Q2.13 angles in, nine Q1.14 entries of the rotation R*P*Y out.
// ----------------------------------------------------------------------------
// channel  | signals                              | handshake
// request  | i_roll/pitch/yaw_angle               | i_start, o_busy (always low)
// result   | o_m00 .. o_m22                       | o_done strobe, one cycle
//
// One request per cycle; the path runs through the angle
// register, one register per CORDIC stage, two product stages, the sum stage
// and the output register.
// Reset clears the valid bits only; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module euler_angles_to_rotation #(
    parameter int CORDIC_STAGES = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    output logic               o_done,
    output logic signed [15:0] o_m00,
    output logic signed [15:0] o_m01,
    output logic signed [15:0] o_m02,
    output logic signed [15:0] o_m10,
    output logic signed [15:0] o_m11,
    output logic signed [15:0] o_m12,
    output logic signed [15:0] o_m20,
    output logic signed [15:0] o_m21,
    output logic signed [15:0] o_m22
);
`include "euler_angles_to_rotation_defines.svh"

    localparam int NS  = (CORDIC_STAGES < ear_pkg::ATAB_LEN) ? CORDIC_STAGES
                                                             : ear_pkg::ATAB_LEN;
    localparam int LAT = NS + 5;
    localparam int SH  = 30 - OUT_FRAC_BITS;
    localparam logic signed [16:0] OUT_LIM = 17'(32'sd1 <<< OUT_FRAC_BITS);

    ear_pkg::t_q30 sr, cr, sp, cp, sy, cy;

    ear_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_angle(i_roll_angle), .o_sin(sr), .o_cos(cr));
    ear_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_angle(i_pitch_angle), .o_sin(sp), .o_cos(cp));
    ear_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_angle(i_yaw_angle), .o_sin(sy), .o_cos(cy));

    // Valid bits travel alongside the data
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    assign o_busy = 1'b0;
    assign o_done = r_vld[LAT-1];

    // Stage A: register trig values and the pitch-mixed terms
    ear_pkg::t_q30 r_sr, r_cr, r_sp, r_cp, r_sy, r_cy, r_srsp, r_crsp;
    always_ff @(posedge i_clk) begin
        r_sr <= sr; r_cr <= cr; r_sp <= sp;
        r_cp <= cp; r_sy <= sy; r_cy <= cy;
        r_srsp <= ear_pkg::qmul(sr, sp);
        r_crsp <= ear_pkg::qmul(cr, sp);
    end

    // Stage B: the second products and the negated pitch sine
    ear_pkg::t_q30 r_p [13];
    always_ff @(posedge i_clk) begin
        r_p[0]  <= ear_pkg::qmul(r_cr, r_cy);
        r_p[1]  <= ear_pkg::qmul(r_srsp, r_sy);
        r_p[2]  <= ear_pkg::qmul(r_sr, r_cp);
        r_p[3]  <= ear_pkg::qmul(r_cr, r_sy);
        r_p[4]  <= ear_pkg::qmul(r_srsp, r_cy);
        r_p[5]  <= ear_pkg::qmul(r_sr, r_cy);
        r_p[6]  <= ear_pkg::qmul(r_crsp, r_sy);
        r_p[7]  <= ear_pkg::qmul(r_cr, r_cp);
        r_p[8]  <= ear_pkg::qmul(r_sr, r_sy);
        r_p[9]  <= ear_pkg::qmul(r_crsp, r_cy);
        r_p[10] <= ear_pkg::qmul(r_cp, r_sy);
        r_p[11] <= -r_sp;
        r_p[12] <= ear_pkg::qmul(r_cp, r_cy);
    end

    // Stage C: sums
    ear_pkg::t_q30 r_s [9];
    always_ff @(posedge i_clk) begin
        r_s[0] <= r_p[0] + r_p[1];
        r_s[1] <= r_p[2];
        r_s[2] <= r_p[4] - r_p[3];
        r_s[3] <= r_p[6] - r_p[5];
        r_s[4] <= r_p[7];
        r_s[5] <= r_p[8] + r_p[9];
        r_s[6] <= r_p[10];
        r_s[7] <= r_p[11];
        r_s[8] <= r_p[12];
    end

    // Round to the output format and saturate
    function automatic logic signed [15:0] to_out(input ear_pkg::t_q30 v);
        ear_pkg::t_q30 t;
        ear_pkg::t_q30 lim;
        begin
            lim = ear_pkg::t_q30'(1) <<< OUT_FRAC_BITS;
            t = v;
            if (SH > 0) begin
                t = (v + (ear_pkg::t_q30'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
            end
            if (t > lim) t = lim;
            if (t < -lim) t = -lim;
            return t[15:0];
        end
    endfunction

    // Output register
    logic signed [15:0] r_m [9];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_m[k] <= to_out(r_s[k]);
        end
    end

    assign o_m00 = r_m[0]; assign o_m01 = r_m[1]; assign o_m02 = r_m[2];
    assign o_m10 = r_m[3]; assign o_m11 = r_m[4]; assign o_m12 = r_m[5];
    assign o_m20 = r_m[6]; assign o_m21 = r_m[7]; assign o_m22 = r_m[8];

    // Range of the pitch entry, checked only where the field holds the limit
    logic m21_ok;
    assign m21_ok = (OUT_FRAC_BITS > 14) || ((o_m21 <= OUT_LIM) && (o_m21 >= -OUT_LIM));

    `EAR_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy, "busy raised")
    `EAR_ASSERT_NEXT(a_vld_shift, i_clk, i_rst_n, i_start, r_vld[0], "request lost")
    `EAR_ASSERT_IMPL(a_m21_range, i_clk, i_rst_n, o_done, m21_ok, "entry out of range")

endmodule
